[rtl/pmc_pkg.sv]
// ----------------------------------------------------------------------------
// pmc_pkg
// Shared types, widths and the tanh table builder for the perceptron
// motor controller.
// ----------------------------------------------------------------------------
package pmc_pkg;

    // sensor vector and weight table layout
    localparam int SENSOR_COUNT = 8;
    localparam int WEIGHT_COUNT = 18;
    localparam int TRANS_BIAS   = 8;
    localparam int ROT_BASE     = 9;
    localparam int ROT_BIAS     = 17;

    // field widths
    localparam int SENSOR_W = 12;
    localparam int WEIGHT_W = 16;
    localparam int WIDX_W   = 5;
    localparam int SPEED_W  = 16;
    localparam int DRIVE_W  = 17;

    // stream packing
    localparam int WIDX_LSB     = 0;
    localparam int WVAL_LSB     = WIDX_LSB + WIDX_W;
    localparam int SENSOR_LSB   = WVAL_LSB + WEIGHT_W;
    localparam int IN_FIELDS_W  = SENSOR_LSB + 8 * SENSOR_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * DRIVE_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int CFG_ADDR_W   = 1;

    // datapath widths
    localparam int PROD_W     = WEIGHT_W + SENSOR_W + 1;
    localparam int PAIR_COUNT = (SENSOR_COUNT + 1) / 2;
    localparam int PAIR_W     = PROD_W + 1;
    localparam int ACC_W      = 32;
    localparam int ACC_SHIFT  = 4;
    localparam int IDX_MAX    = 2047;
    localparam int TANH_DEPTH = IDX_MAX + 1;
    localparam int IDX_W      = $clog2(TANH_DEPTH);
    localparam int TANH_W     = 15;
    localparam int TANH_SCALE = 32767;
    localparam int TANH_SHIFT = 15;
    localparam int MAG_W      = TANH_W + SPEED_W;

    localparam int PIPE_STAGES = 6;

    localparam logic [SPEED_W-1:0] MAX_TRANS_RESET = SPEED_W'(512);
    localparam logic [SPEED_W-1:0] MAX_ROT_RESET   = SPEED_W'(2560);

    typedef enum logic [0:0] {
        KIND_LOAD = 1'b0,
        KIND_EVAL = 1'b1
    } t_kind;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MAX_TRANS = 1'b0,
        REG_MAX_ROT   = 1'b1
    } t_cfg_reg;

    // per-stage load enables, driven from the valid/ready chain
    typedef struct packed {
        logic lane;
        logic pair;
        logic sum;
        logic rom;
        logic mul;
        logic out;
    } t_pipe_ctl;

    typedef logic signed [PROD_W-1:0] t_prod;

    typedef struct packed {
        logic             neg;
        logic [IDX_W-1:0] mag;
    } t_tanh_arg;

    typedef logic [TANH_W-1:0] t_tanh_rom [TANH_DEPTH];

    localparam logic [63:0] Q62_ONE = 64'd1 << 62;
    localparam logic [63:0] Q40_ONE = 64'd1 << 40;

    // shift-subtract divide, used only while building the table
    function automatic logic [63:0] udiv_const(input logic [63:0] num,
                                               input logic [63:0] den,
                                               input int          qbits);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = {1'b0, num} >> qbits;
        quo = '0;
        for (int b = qbits - 1; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // (a * b) >> 62 in 64-bit arithmetic
    function automatic logic [63:0] mul_q62(input logic [63:0] a,
                                            input logic [63:0] b);
        logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
        al  = {32'd0, a[31:0]};
        ah  = {32'd0, a[63:32]};
        bl  = {32'd0, b[31:0]};
        bh  = {32'd0, b[63:32]};
        ll  = al * bl;
        lh  = al * bh;
        hl  = ah * bl;
        hh  = ah * bh;
        mid = (ll >> 32) + {32'd0, lh[31:0]} + {32'd0, hl[31:0]};
        lo  = {mid[31:0], ll[31:0]};
        hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
        return (hi << 2) | (lo >> 62);
    endfunction

    // round(tanh(n/256) * 32767) for n = 0..2047, exact integer build
    function automatic t_tanh_rom build_tanh_rom();
        t_tanh_rom   rom;
        logic [63:0] term, c, u, uq, num, den, q;
        term = Q62_ONE;
        c    = Q62_ONE;
        u    = Q62_ONE;
        // c = exp(-1/128) from its series
        for (int k = 1; k < 20; k++) begin
            term = udiv_const(term, 64'(128 * k), 64);
            if (k[0]) begin
                c = c - term;
            end else begin
                c = c + term;
            end
        end
        for (int i = 0; i < TANH_DEPTH; i++) begin
            uq     = u >> 22;
            num    = 64'(2 * TANH_SCALE) * (Q40_ONE - uq) + (Q40_ONE + uq);
            den    = (Q40_ONE + uq) << 1;
            q      = udiv_const(num, den, 16);
            rom[i] = q[TANH_W-1:0];
            u      = mul_q62(u, c);
        end
        return rom;
    endfunction

endpackage

[rtl/perceptron_motor_controller.sv]
// ----------------------------------------------------------------------------
// perceptron_motor_controller
// Single-layer perceptron with tanh activation turning eight sensor
// distances into translation and rotation drive commands.
// ----------------------------------------------------------------------------
// A beat with tuser low loads one Q3.12 weight into the 18-entry table
// (cleared to zero by reset) and gives no result; an index above 17 is
// dropped. A beat with tuser high evaluates the sensors: eight lanes form
// the weight-by-sensor products in parallel, a registered adder tree adds
// them with the bias, and a tanh ROM lookup scaled by the configured
// maximum speed gives each drive. The block takes one beat per cycle
// while o_s_tready is high (a held, full pipe stalls it); of the six
// pipeline stages (lane multiply, pair add, final add and saturate, ROM read,
// speed multiply, output register) the first is loaded by the input beat
// itself. A stage holds only while every stage ahead of it is full and the
// output register is held by the downstream side, so bubbles close up. A
// weight load takes effect for the very next evaluate beat. Speed registers
// should be written only while no evaluate is in flight.
// ----------------------------------------------------------------------------
module perceptron_motor_controller import pmc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave side
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // weight_index, weight_value, sensor_0 .. sensor_7, zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // kind
    input  logic                   i_s_tuser,
    // master side
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // translation_drive, rotation_drive, zero pad
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [SPEED_W-1:0]     i_cfg_wdata
);

    logic signed [WEIGHT_W-1:0] r_weight [WEIGHT_COUNT];
    logic [SPEED_W-1:0]         r_max_trans;
    logic [SPEED_W-1:0]         r_max_rot;
    logic [PIPE_STAGES-1:0]     r_vld;
    logic [PIPE_STAGES-1:0]     n_vld;
    logic [PIPE_STAGES-1:0]     rdy;
    logic                       s_beat;
    logic                       load_beat;
    logic                       eval_beat;
    logic [WIDX_W-1:0]          widx;
    logic signed [WEIGHT_W-1:0] wval;
    t_pipe_ctl                  ctl;
    t_prod [SENSOR_COUNT-1:0]   prod_t;
    t_prod [SENSOR_COUNT-1:0]   prod_r;
    t_tanh_arg                  arg_t;
    t_tanh_arg                  arg_r;
    logic signed [DRIVE_W-1:0]  drive_t;
    logic signed [DRIVE_W-1:0]  drive_r;

    // ready chain from the output register back to the input
    always_comb begin
        rdy[PIPE_STAGES-1] = !r_vld[PIPE_STAGES-1] || i_m_tready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign o_s_tready = rdy[0];
    assign s_beat     = i_s_tvalid && rdy[0];
    assign load_beat  = s_beat && (t_kind'(i_s_tuser) == KIND_LOAD);
    assign eval_beat  = s_beat && (t_kind'(i_s_tuser) == KIND_EVAL);
    assign widx       = i_s_tdata[WIDX_LSB +: WIDX_W];
    assign wval       = $signed(i_s_tdata[WVAL_LSB +: WEIGHT_W]);

    always_comb begin
        n_vld[0] = rdy[0] ? eval_beat : r_vld[0];
        for (int k = 1; k < PIPE_STAGES; k++) begin
            n_vld[k] = rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_comb begin
        ctl.lane = rdy[0];
        ctl.pair = rdy[1];
        ctl.sum  = rdy[2];
        ctl.rom  = rdy[3];
        ctl.mul  = rdy[4];
        ctl.out  = rdy[5];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < WEIGHT_COUNT; j++) begin
                r_weight[j] <= '0;
            end
        end else if (load_beat) begin
            for (int j = 0; j < WEIGHT_COUNT; j++) begin
                if (widx == WIDX_W'(j)) begin
                    r_weight[j] <= wval;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_trans <= MAX_TRANS_RESET;
            r_max_rot   <= MAX_ROT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                REG_MAX_TRANS: begin
                    r_max_trans <= i_cfg_wdata;
                end
                REG_MAX_ROT: begin
                    r_max_rot <= i_cfg_wdata;
                end
            endcase
        end
    end

    for (genvar k = 0; k < SENSOR_COUNT; k++) begin : g_lane
        pmc_lane u_lane (
            .i_clk      (i_clk),
            .i_en       (ctl.lane),
            .i_sensor   (i_s_tdata[SENSOR_LSB + k*SENSOR_W +: SENSOR_W]),
            .i_weight_t (r_weight[k]),
            .i_weight_r (r_weight[ROT_BASE + k]),
            .o_prod_t   (prod_t[k]),
            .o_prod_r   (prod_r[k])
        );
    end

    pmc_merge u_merge_t (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_prod (prod_t),
        .i_bias (r_weight[TRANS_BIAS]),
        .o_arg  (arg_t)
    );

    pmc_merge u_merge_r (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_prod (prod_r),
        .i_bias (r_weight[ROT_BIAS]),
        .o_arg  (arg_r)
    );

    pmc_drive u_drive_t (
        .i_clk       (i_clk),
        .i_ctl       (ctl),
        .i_arg       (arg_t),
        .i_max_speed (r_max_trans),
        .o_drive     (drive_t)
    );

    pmc_drive u_drive_r (
        .i_clk       (i_clk),
        .i_ctl       (ctl),
        .i_arg       (arg_r),
        .i_max_speed (r_max_rot),
        .o_drive     (drive_r)
    );

    assign o_m_tvalid = r_vld[PIPE_STAGES-1];
    assign o_m_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), drive_r, drive_t};

endmodule

[rtl/pmc_lane.sv]
// ----------------------------------------------------------------------------
// pmc_lane
// One sensor lane: multiplies a sensor reading by its translation and
// rotation weights and registers both products.
// ----------------------------------------------------------------------------
module pmc_lane import pmc_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [SENSOR_W-1:0]        i_sensor,
    input  logic signed [WEIGHT_W-1:0] i_weight_t,
    input  logic signed [WEIGHT_W-1:0] i_weight_r,
    output t_prod                      o_prod_t,
    output t_prod                      o_prod_r
);

    logic signed [SENSOR_W:0] sensor_s;
    t_prod                    n_prod_t;
    t_prod                    n_prod_r;
    t_prod                    r_prod_t;
    t_prod                    r_prod_r;

    assign sensor_s = $signed({1'b0, i_sensor});

    always_comb begin
        n_prod_t = i_weight_t * sensor_s;
        n_prod_r = i_weight_r * sensor_s;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_t <= n_prod_t;
            r_prod_r <= n_prod_r;
        end
    end

    assign o_prod_t = r_prod_t;
    assign o_prod_r = r_prod_r;

endmodule

[rtl/pmc_merge.sv]
// ----------------------------------------------------------------------------
// pmc_merge
// Adds the lane products of one channel and its bias in a two-level
// registered tree, then scales and saturates the sum into a tanh index.
// ----------------------------------------------------------------------------
module pmc_merge import pmc_pkg::*; (
    input  logic                           i_clk,
    input  t_pipe_ctl                      i_ctl,
    input  t_prod [SENSOR_COUNT-1:0]       i_prod,
    input  logic signed [WEIGHT_W-1:0]     i_bias,
    output t_tanh_arg                      o_arg
);

    localparam logic signed [ACC_W-1:0] IdxHi = ACC_W'(IDX_MAX);
    localparam logic signed [ACC_W-1:0] IdxLo = -IdxHi;

    logic signed [WEIGHT_W-1:0] r_bias_lane;
    logic signed [WEIGHT_W-1:0] r_bias_pair;
    logic signed [PAIR_W-1:0]   n_pair [PAIR_COUNT];
    logic signed [PAIR_W-1:0]   r_pair [PAIR_COUNT];
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    idx;
    logic signed [ACC_W-1:0]    idx_abs;
    t_tanh_arg                  n_arg;
    t_tanh_arg                  r_arg;

    // bias travels beside the products so it matches the same weight snapshot
    always_ff @(posedge i_clk) begin
        if (i_ctl.lane) begin
            r_bias_lane <= i_bias;
        end
        if (i_ctl.pair) begin
            r_bias_pair <= r_bias_lane;
        end
    end

    for (genvar k = 0; k < PAIR_COUNT; k++) begin : g_pair
        if (2 * k + 1 < SENSOR_COUNT) begin : g_two
            assign n_pair[k] = PAIR_W'($signed(i_prod[2*k]))
                             + PAIR_W'($signed(i_prod[2*k+1]));
        end else begin : g_one
            assign n_pair[k] = PAIR_W'($signed(i_prod[2*k]));
        end
        always_ff @(posedge i_clk) begin
            if (i_ctl.pair) begin
                r_pair[k] <= n_pair[k];
            end
        end
    end

    always_comb begin
        acc = ACC_W'(r_bias_pair);
        for (int k = 0; k < PAIR_COUNT; k++) begin
            acc = acc + ACC_W'(r_pair[k]);
        end
        // arithmetic shift gives the floor
        idx     = acc >>> ACC_SHIFT;
        idx_abs = (idx < 0) ? -idx : idx;
        if (idx > IdxHi) begin
            n_arg.neg = 1'b0;
            n_arg.mag = IDX_W'(IDX_MAX);
        end else if (idx < IdxLo) begin
            n_arg.neg = 1'b1;
            n_arg.mag = IDX_W'(IDX_MAX);
        end else begin
            n_arg.neg = idx < 0;
            n_arg.mag = idx_abs[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sum) begin
            r_arg <= n_arg;
        end
    end

    assign o_arg = r_arg;

endmodule

[rtl/pmc_drive.sv]
// ----------------------------------------------------------------------------
// pmc_drive
// Looks up tanh of the index in a constant ROM, scales it by the maximum
// speed and forms the signed Q8.8 drive of one channel.
// ----------------------------------------------------------------------------
module pmc_drive import pmc_pkg::*; (
    input  logic                      i_clk,
    input  t_pipe_ctl                 i_ctl,
    input  t_tanh_arg                 i_arg,
    input  logic [SPEED_W-1:0]        i_max_speed,
    output logic signed [DRIVE_W-1:0] o_drive
);

    localparam t_tanh_rom TanhRom = build_tanh_rom();

    logic [TANH_W-1:0]          r_tanh;
    logic                       r_neg_rom;
    logic [MAG_W-1:0]           r_mag;
    logic                       r_neg_mul;
    logic signed [MAG_W:0]      prod_s;
    logic signed [MAG_W:0]      prod_sh;
    logic signed [DRIVE_W-1:0]  n_drive;
    logic signed [DRIVE_W-1:0]  r_drive;

    always_ff @(posedge i_clk) begin
        if (i_ctl.rom) begin
            r_tanh    <= TanhRom[i_arg.mag];
            r_neg_rom <= i_arg.neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_mag     <= MAG_W'(r_tanh) * MAG_W'(i_max_speed);
            r_neg_mul <= r_neg_rom;
        end
    end

    // odd table: negate the product, then floor shift
    always_comb begin
        prod_s  = r_neg_mul ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
        prod_sh = prod_s >>> TANH_SHIFT;
        n_drive = prod_sh[DRIVE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out) begin
            r_drive <= n_drive;
        end
    end

    assign o_drive = r_drive;

endmodule

[rtl/pmc_checker.sv]
// ----------------------------------------------------------------------------
// pmc_checker
// Port-level checks for the perceptron motor controller, bound to the
// top level.
// ----------------------------------------------------------------------------
module pmc_checker import pmc_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   i_s_tready,
    input logic                   i_s_tuser,
    input logic                   i_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] i_m_tdata
);

    logic [3:0] r_pending;
    logic [3:0] n_pending;
    logic       eval_beat;
    logic       out_beat;

    assign eval_beat = i_s_tvalid && i_s_tready && (t_kind'(i_s_tuser) == KIND_EVAL);
    assign out_beat  = i_m_tvalid && i_m_tready;

    // evaluate beats not yet answered
    always_comb begin
        n_pending = r_pending + 4'(eval_beat) - 4'(out_beat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("stalled result beat changed");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> r_pending != 4'd0)
        else $error("result beat without an evaluate beat");

    a_free_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_m_tvalid |-> i_s_tready)
        else $error("input stalled with output register empty");

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> i_m_tdata[DRIVE_W-1:0] != {1'b1, {(DRIVE_W-1){1'b0}}}
                    && i_m_tdata[2*DRIVE_W-1:DRIVE_W] != {1'b1, {(DRIVE_W-1){1'b0}}})
        else $error("drive outside symmetric range");

endmodule

bind perceptron_motor_controller pmc_checker u_pmc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stream-level check of the perceptron motor controller: weight loads and
// sensor evaluations are driven with bursty input and a stalling output,
// and every drive pair is compared against an independent fixed-point
// tanh perceptron model kept in the bench.
// ----------------------------------------------------------------------------
module tb_top import pmc_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_CYCLES   = PIPE_STAGES + 6;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int STALL_LIMIT    = 5000;
    localparam int PHASE_ITEMS    = 245;

    typedef struct packed {
        logic [DRIVE_W-1:0] trans;
        logic [DRIVE_W-1:0] rot;
    } t_drive_pair;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // weight_index, weight_value, sensor_0 .. sensor_7, zero pad
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    // kind
    logic                   i_s_tuser = 1'b0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // translation_drive, rotation_drive, zero pad
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [SPEED_W-1:0]     i_cfg_wdata = '0;

    // bench copy of the controller state
    logic [TANH_W-1:0]          tanh_tab [TANH_DEPTH];
    logic signed [WEIGHT_W-1:0] nn_weight [WEIGHT_COUNT];
    logic [SPEED_W-1:0]         max_trans_spd = MAX_TRANS_RESET;
    logic [SPEED_W-1:0]         max_rot_spd = MAX_ROT_RESET;
    t_drive_pair                pending_drives [$];

    int error_count = 0;
    int idle_cycles = 0;

    // sender pacing
    bit tx_bursty = 1'b0;
    int tx_burst_left = 0;

    // receiver stall pattern
    bit          rx_hold_req = 1'b0;
    int          rx_hold_left = 0;
    int          rx_epoch_left = 0;
    logic [15:0] rx_pat = 16'hFFFF;
    int          rx_phase = 0;

    perceptron_motor_controller i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // round(tanh(n/256) * 32767), built with exact integer math
    task automatic fill_tanh_table();
        logic [63:0]  term, c, u, uq, num, den, one40;
        logic [127:0] wide;
        int           k, n;
        term  = 64'd1 << 62;
        c     = term;
        u     = term;
        one40 = 64'd1 << 40;
        // c = exp(-1/128) as a Q62 series
        for (k = 1; k < 20; k++) begin
            term = term / (64'd128 * 64'(k));
            if (k % 2 == 1) begin
                c = c - term;
            end else begin
                c = c + term;
            end
        end
        for (n = 0; n < TANH_DEPTH; n++) begin
            uq          = u >> 22;
            num         = 64'd65534 * (one40 - uq) + (one40 + uq);
            den         = (one40 + uq) << 1;
            tanh_tab[n] = TANH_W'(num / den);
            wide        = {64'd0, u} * {64'd0, c};
            u           = 64'(wide >> 62);
        end
    endtask

    function automatic logic [DRIVE_W-1:0] scaled_tanh(longint acc,
                                                       logic [SPEED_W-1:0] maxspd);
        longint idx, t, prod;
        idx = acc >>> 4;
        if (idx > IDX_MAX) idx = IDX_MAX;
        if (idx < -IDX_MAX) idx = -IDX_MAX;
        t    = (idx >= 0) ? longint'(tanh_tab[idx]) : -longint'(tanh_tab[-idx]);
        prod = t * longint'(maxspd);
        return DRIVE_W'(prod >>> 15);
    endfunction

    task automatic predict_beat(logic kind, logic [IN_TDATA_W-1:0] data);
        logic [WIDX_W-1:0]   widx;
        logic [SENSOR_W-1:0] sens;
        longint              tacc, racc;
        t_drive_pair         res;
        widx = data[WIDX_LSB +: WIDX_W];
        if (kind == KIND_LOAD) begin
            // out-of-range index is dropped
            if (widx < WEIGHT_COUNT) nn_weight[widx] = data[WVAL_LSB +: WEIGHT_W];
        end else begin
            tacc = longint'(nn_weight[TRANS_BIAS]);
            racc = longint'(nn_weight[ROT_BIAS]);
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                sens = data[SENSOR_LSB + i * SENSOR_W +: SENSOR_W];
                tacc += longint'(nn_weight[i]) * longint'(sens);
                racc += longint'(nn_weight[ROT_BASE + i]) * longint'(sens);
            end
            res.trans = scaled_tanh(tacc, max_trans_spd);
            res.rot   = scaled_tanh(racc, max_rot_spd);
            pending_drives.push_back(res);
        end
    endtask

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // input beats feed the model, output beats are checked in order
    always @(posedge i_clk) begin : scoreboard
        t_drive_pair want;
        logic [DRIVE_W-1:0] got_trans, got_rot;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got_trans = o_m_tdata[0 +: DRIVE_W];
                got_rot   = o_m_tdata[DRIVE_W +: DRIVE_W];
                if (pending_drives.size() == 0) begin
                    report_mismatch($sformatf("unexpected result beat %h", o_m_tdata));
                end else begin
                    want = pending_drives.pop_front();
                    if (got_trans !== want.trans)
                        report_mismatch($sformatf("translation_drive %0d, expected %0d",
                                                  $signed(got_trans), $signed(want.trans)));
                    if (got_rot !== want.rot)
                        report_mismatch($sformatf("rotation_drive %0d, expected %0d",
                                                  $signed(got_rot), $signed(want.rot)));
                end
            end
            if (i_s_tvalid && o_s_tready) predict_beat(i_s_tuser, i_s_tdata);
        end
    end

    // receiver: stall pattern per epoch, plus a long hold on request
    always @(negedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_left = RX_HOLD_CYCLES;
            rx_hold_req  = 1'b0;
        end
        if (rx_epoch_left == 0) begin
            rx_epoch_left = $urandom_range(16, 200);
            rx_pat        = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
        end else begin
            rx_epoch_left--;
        end
        rx_phase = (rx_phase + 1) % 16;
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= rx_pat[rx_phase];
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_beat(t_kind kind, logic [WIDX_W-1:0] widx,
                             logic [WEIGHT_W-1:0] wval,
                             logic [8*SENSOR_W-1:0] sens);
        int gap;
        if (tx_bursty && tx_burst_left == 0) begin
            gap = $urandom_range(1, 12);
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            tx_burst_left = $urandom_range(1, 40);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= IN_TDATA_W'({sens, wval, widx});
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (tx_burst_left > 0) tx_burst_left--;
    endtask

    task automatic load_weight(logic [WIDX_W-1:0] widx, logic [WEIGHT_W-1:0] wval);
        send_beat(KIND_LOAD, widx, wval, {$urandom, $urandom, $urandom});
    endtask

    task automatic evaluate(logic [8*SENSOR_W-1:0] sens);
        send_beat(KIND_EVAL, WIDX_W'($urandom), WEIGHT_W'($urandom), sens);
    endtask

    // stop offering beats, let all results arrive and the pipe settle
    task automatic wait_quiet();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_drives.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_speed(t_cfg_reg which, logic [SPEED_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= which;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        if (which == REG_MAX_TRANS) max_trans_spd = value;
        else max_rot_spd = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(0, 4))
            0: return WEIGHT_W'($urandom_range(0, 8) - 4);
            1: return WEIGHT_W'($urandom_range(0, 128) - 64);
            2: return WEIGHT_W'($urandom_range(0, 8192) - 4096);
            3: return WEIGHT_W'($urandom);
            default: begin
                case ($urandom_range(0, 3))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'hFFFF;
                    default: return 16'h0000;
                endcase
            end
        endcase
    endfunction

    function automatic logic [8*SENSOR_W-1:0] rand_sensors();
        logic [8*SENSOR_W-1:0] sens;
        int                    style;
        style = $urandom_range(0, 3);
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            case (style)
                0: sens[i*SENSOR_W +: SENSOR_W] = SENSOR_W'($urandom);
                1: sens[i*SENSOR_W +: SENSOR_W] = SENSOR_W'($urandom_range(0, 63));
                2: sens[i*SENSOR_W +: SENSOR_W] = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
                default: sens[i*SENSOR_W +: SENSOR_W] = SENSOR_W'($urandom_range(0, 400));
            endcase
        end
        return sens;
    endfunction

    function automatic logic [SPEED_W-1:0] rand_speed();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return SPEED_W'($urandom);
        endcase
    endfunction

    task automatic random_item();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 4) load_weight(WIDX_W'($urandom_range(WEIGHT_COUNT, 31)), rand_weight());
        else if (sel < 36) load_weight(WIDX_W'($urandom_range(0, WEIGHT_COUNT - 1)),
                                       rand_weight());
        else evaluate(rand_sensors());
    endtask

    // cleared weight table gives zero drive at the reset speeds
    task automatic test_reset_state();
        evaluate({8{12'hFFF}});
        evaluate('0);
    endtask

    task automatic test_field_extremes();
        load_weight(5'd0, 16'h7FFF);
        load_weight(5'd9, 16'h8000);
        evaluate({8{12'hFFF}});
        // indexes past the table must leave it untouched
        load_weight(5'd31, 16'h8000);
        load_weight(5'd18, 16'h7FFF);
        evaluate({8{12'hFFF}});
        // bias only, with a negative sum that floors away from zero
        load_weight(5'd0, 16'h0000);
        load_weight(5'd9, 16'h0000);
        load_weight(5'd8, 16'h0010);
        load_weight(5'd17, 16'hFFEF);
        evaluate('0);
        load_weight(5'd8, 16'h8000);
        load_weight(5'd17, 16'h7FFF);
        evaluate('0);
        load_weight(5'd7, 16'hFFFF);
        load_weight(5'd16, 16'h0001);
        evaluate({8{12'hFFF}});
        load_weight(5'd8, 16'h0000);
        load_weight(5'd17, 16'h0000);
        evaluate({12'hFFF, 84'd0});
        evaluate({8{12'h001}});
        evaluate({8{12'hAAA}});
        evaluate({8{12'h555}});
    endtask

    task automatic test_speed_extremes();
        logic [SPEED_W-1:0] trans_set [5] = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0200};
        logic [SPEED_W-1:0] rot_set [5]   = '{16'hFFFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h0A00};
        for (int s = 0; s < 5; s++) begin
            wait_quiet();
            write_speed(REG_MAX_TRANS, trans_set[s]);
            write_speed(REG_MAX_ROT, rot_set[s]);
            load_weight(WIDX_W'($urandom_range(0, WEIGHT_COUNT - 1)), rand_weight());
            load_weight(WIDX_W'($urandom_range(0, WEIGHT_COUNT - 1)), rand_weight());
            repeat (3) evaluate(rand_sensors());
        end
    endtask

    // output held off while input keeps coming, then a full drain
    task automatic test_backpressure();
        tx_bursty = 1'b0;
        wait_quiet();
        rx_hold_req = 1'b1;
        repeat (40) random_item();
        wait_quiet();
    endtask

    task automatic test_random_mix();
        for (int p = 0; p < 6; p++) begin
            wait_quiet();
            write_speed(REG_MAX_TRANS, rand_speed());
            write_speed(REG_MAX_ROT, rand_speed());
            tx_bursty = (p % 3 != 2);
            repeat (PHASE_ITEMS) random_item();
        end
    endtask

    initial begin
        fill_tanh_table();
        foreach (nn_weight[i]) nn_weight[i] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        tx_bursty = 1'b1;

        test_reset_state();
        test_field_extremes();
        test_speed_extremes();
        test_backpressure();
        test_random_mix();

        wait_quiet();
        repeat (2 * PIPE_STAGES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
